### hdl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared constants, codes and the word search function of the allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Map geometry and field widths
  localparam int unsigned MAP_BITS_DEF = 4096;
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned BIT_W        = 6;
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned CNT_W        = 13;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned REL_LAST     = 4095;
  localparam int unsigned TOTAL_RESET  = 4096;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 2'd0,
    OP_MARK_USED = 2'd1,
    OP_MARK_FREE = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_BLOCKS = 1'd0,
    CFG_DATA_START   = 1'd1
  } cfg_idx_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_READ  = 2'd2,
    S_DONE  = 2'd3
  } state_e;

  // Lowest set bit of a map word: pick the byte first, then the bit in it
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [7:0] any;
    logic [7:0] sel_byte;
    logic [2:0] byte_sel;
    logic [2:0] bit_sel;
    for (int k = 0; k < 8; k++) begin
      any[k] = |v[8*k +: 8];
    end
    byte_sel = '0;
    for (int k = 7; k >= 0; k--) begin
      if (any[k]) byte_sel = 3'(k);
    end
    sel_byte = v[8*byte_sel +: 8];
    bit_sel = '0;
    for (int k = 7; k >= 0; k--) begin
      if (sel_byte[k]) bit_sel = 3'(k);
    end
    return {byte_sel, bit_sel};
  endfunction

endpackage

### hdl/bba_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy map memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_map_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one word a cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bitmap_block_allocator_unit.sv
`timescale 1ns / 1ps
// Allocate scans the map words of the search window in order, up to 64 by default
//   (one 64-bit word per cycle through the map memory read port).
// Mark requests read the map word and write it back; out-of-range and unknown requests go straight to the result.
// One request is worked at a time; the next is accepted right after the result
//   moves to the output register, which may still wait on the consumer.
// Reset: a clearing pass writes zero to each map word, input stalled.
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a one-bit-per-block occupancy map held in memory.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit #(
  parameter int unsigned MAP_BITS = bba_pkg::MAP_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration writes
  input  logic                           cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bba_pkg::CNT_W-1:0]      cfg_data_i,
  // Request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bba_pkg::OP_W-1:0]       op_i,
  input  logic [bba_pkg::IDX_W-1:0]      block_index_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bba_pkg::IDX_W-1:0]      block_number_o,
  output logic [bba_pkg::STAT_W-1:0]     status_o,
  output logic [bba_pkg::CNT_W-1:0]      free_blocks_o
);

  import bba_pkg::*;

  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned ABS_W     = ((MAP_BITS > 8192) ? $clog2(MAP_BITS) : 13) + 1;
  localparam int unsigned USE_W     = $clog2(MAP_BITS + 1);
  localparam int unsigned FW        = (USE_W > CNT_W) ? USE_W : CNT_W;
  localparam logic [ABS_W-1:0] ABS_LAST  = ABS_W'(MAP_BITS - 1);
  localparam logic [WA-1:0]    WORD_LAST = WA'(MAP_WORDS - 1);

  // Configuration
  logic [CNT_W-1:0] total_q;
  logic [IDX_W-1:0] dstart_q;

  // Sequencer and request state
  state_e            state_q, state_d;
  logic [OP_W-1:0]   op_q;
  logic [ABS_W-1:0]  mark_abs_q;
  logic [WA-1:0]     word_q, word_d;
  logic [WA-1:0]     clr_q, clr_d;
  logic [USE_W-1:0]  used_q, used_d;
  logic [IDX_W-1:0]  res_num_q, res_num_d;
  status_e           res_st_q, res_st_d;

  // Output register
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_num_q;
  status_e           out_st_q;
  logic [CNT_W-1:0]  out_free_q;

  // Memory port
  logic              ram_we;
  logic [WA-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, rd_data;

  // Address and window arithmetic
  logic [ABS_W-1:0]  ds_ext, mark_abs, ds_sum, end_abs, hit_abs;
  logic [WA-1:0]     start_word, end_word, mark_word;
  logic [BIT_W-1:0]  win_lo, win_hi, hit_pos, mark_pos;
  logic [WORD_W-1:0] win_mask, cand, hit_bit, mark_bit;
  logic [IDX_W-1:0]  granted;
  logic              in_acc, out_load, mark_was, mark_set;
  logic [FW-1:0]     total_ext, used_ext;
  logic [CNT_W-1:0]  free_now;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign ds_ext     = ABS_W'(dstart_q);
  assign mark_abs   = ds_ext + ABS_W'(block_index_i);
  assign ds_sum     = ds_ext + ABS_W'(REL_LAST);
  assign end_abs    = (ds_sum > ABS_LAST) ? ABS_LAST : ds_sum;
  assign start_word = WA'(ds_ext >> BIT_W);
  assign end_word   = WA'(end_abs >> BIT_W);
  assign mark_word  = WA'(mark_abs >> BIT_W);

  // Search window of the current word: at or above data_start, up to the end
  assign win_lo   = (word_q == start_word) ? dstart_q[BIT_W-1:0] : '0;
  assign win_hi   = (word_q == end_word) ? end_abs[BIT_W-1:0] : '1;
  assign win_mask = ({WORD_W{1'b1}} << win_lo) &
                    ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - win_hi));
  assign cand     = ~rd_data & win_mask;
  assign hit_pos  = first_set(cand);
  assign hit_bit  = WORD_W'(1) << hit_pos;
  assign hit_abs  = ABS_W'({word_q, hit_pos});
  assign granted  = IDX_W'(hit_abs - ds_ext);

  // Mark target bit
  assign mark_pos = mark_abs_q[BIT_W-1:0];
  assign mark_bit = WORD_W'(1) << mark_pos;
  assign mark_was = rd_data[mark_pos];
  assign mark_set = (op_q == OP_MARK_USED);

  // Free count, saturating at zero
  assign total_ext = FW'(total_q);
  assign used_ext  = FW'(used_q);
  assign free_now  = (total_ext >= used_ext) ? CNT_W'(total_ext - used_ext) : '0;

  bba_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (WA),
    .DW    (WORD_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  // Next state, memory access and result
  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    clr_d     = clr_q;
    used_d    = used_q;
    res_num_d = res_num_q;
    res_st_d  = res_st_q;
    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = rd_data;
    ram_raddr = word_q;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + WA'(1);
        if (clr_q == WORD_LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (op_e'(op_i))
            OP_ALLOC: begin
              if (ds_ext > ABS_LAST) begin
                res_num_d = '0;
                res_st_d  = ST_NO_FREE;
                state_d   = S_DONE;
              end else begin
                ram_raddr = start_word;
                word_d    = start_word;
                state_d   = S_READ;
              end
            end
            OP_MARK_USED, OP_MARK_FREE: begin
              if (mark_abs > ABS_LAST) begin
                res_num_d = '0;
                res_st_d  = ST_RANGE;
                state_d   = S_DONE;
              end else begin
                ram_raddr = mark_word;
                word_d    = mark_word;
                state_d   = S_READ;
              end
            end
            default: begin
              res_num_d = '0;
              res_st_d  = ST_RANGE;
              state_d   = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        case (op_e'(op_q))
          OP_ALLOC: begin
            if (|cand) begin
              ram_we    = 1'b1;
              ram_wdata = rd_data | hit_bit;
              used_d    = used_q + USE_W'(1);
              res_num_d = granted;
              res_st_d  = ST_OK;
              state_d   = S_DONE;
            end else if (word_q == end_word) begin
              res_num_d = '0;
              res_st_d  = ST_NO_FREE;
              state_d   = S_DONE;
            end else begin
              ram_raddr = word_q + WA'(1);
              word_d    = word_q + WA'(1);
            end
          end
          default: begin
            ram_we    = 1'b1;
            ram_wdata = mark_set ? (rd_data | mark_bit) : (rd_data & ~mark_bit);
            if (mark_set && !mark_was) used_d = used_q + USE_W'(1);
            if (!mark_set && mark_was) used_d = used_q - USE_W'(1);
            res_num_d = '0;
            res_st_d  = ST_OK;
            state_d   = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      total_q     <= CNT_W'(TOTAL_RESET);
      dstart_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_TOTAL_BLOCKS: total_q  <= cfg_data_i;
          CFG_DATA_START:   dstart_q <= cfg_data_i[IDX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    res_num_q <= res_num_d;
    res_st_q  <= res_st_d;
    if (in_acc) begin
      op_q       <= op_i;
      mark_abs_q <= mark_abs;
    end
    if (out_load) begin
      out_num_q  <= res_num_q;
      out_st_q   <= res_st_q;
      out_free_q <= free_now;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign block_number_o = out_num_q;
  assign status_o       = out_st_q;
  assign free_blocks_o  = out_free_q;

endmodule

### hdl/bba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Port-level assertions on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bba_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [bba_pkg::IDX_W-1:0]      block_number_o,
  input logic [bba_pkg::STAT_W-1:0]     status_o
);

  import bba_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(block_number_o) &&
    $stable(status_o))
    else $error("stalled result beat changed");

  // Keep the input stalled as reset releases and the clearing pass begins
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("request taken during clearing pass");

  // Work one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in flight");

  // Grant no block number on failure
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NO_FREE || status_o == ST_RANGE) |->
    block_number_o == '0)
    else $error("failed request reports a block number");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);
